@@ design/iss_pkg.sv @@
`default_nettype none

package iss_pkg;

  // Storage size and word width of the store.
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;

  // Derived widths: entry address, entry count, and a compare width that
  // covers both the count and the position field.
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // Fixed widths of the item fields.
  localparam int MODE_W = 3;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_RM_AT     = 3'd1,
    MODE_RM_FIRST  = 3'd2,
    MODE_RM_LAST   = 3'd3,
    MODE_RM_VALUE  = 3'd4,
    MODE_REPLACE   = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic                  valid;
    status_e               status;
    logic [VAL_W-1:0]      removed_value;
    logic [LEN_W-1:0]      length;
  } res_t;

endpackage

`default_nettype wire

@@ design/iss_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/iss_ctrl.sv @@
`default_nettype none

// Request sequencer: checks each request, writes appends and replaces directly, and for other
// inserts and removals streams reads through the entry RAM and writes each word back one place up or down.
module iss_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [iss_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [iss_pkg::POS_W-1:0]     position_i,
  input  wire logic [iss_pkg::VAL_W-1:0]     value_i,
  output iss_pkg::res_t                      res_o,
  input  wire logic                          res_ready_i,
  output logic                               ram_we_o,
  output logic [iss_pkg::ADDR_W-1:0]         ram_waddr_o,
  output logic [iss_pkg::DATA_WIDTH-1:0]     ram_wdata_o,
  output logic                               ram_re_o,
  output logic [iss_pkg::ADDR_W-1:0]         ram_raddr_o,
  input  wire logic [iss_pkg::DATA_WIDTH-1:0] ram_rdata_i
);

  import iss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_FIN
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      count_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [ADDR_W-1:0]     pos_q;
  logic [ADDR_W-1:0]     rd_addr_q;
  logic                  issue_q;
  logic                  rv_q;
  logic [ADDR_W-1:0]     ra_q;
  logic                  found_q;
  logic                  force_q;
  logic [DATA_WIDTH-1:0] removed_q;
  status_e               status_q;

  logic                  accept;
  logic [CMP_W-1:0]      cnt_c;
  logic [CMP_W-1:0]      pos_c;
  logic [ADDR_W-1:0]     pos_a;
  logic [ADDR_W-1:0]     last_a;
  logic                  empty;
  logic                  full;
  logic                  direct_wr;
  logic                  hit;
  mode_e                 mode;

  // Request decode helpers.
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign mode   = mode_e'(mode_i);
  assign cnt_c  = CMP_W'(count_q);
  assign pos_c  = CMP_W'(position_i);
  assign pos_a  = ADDR_W'(position_i);
  assign last_a = ADDR_W'(count_q - CNT_W'(1));
  assign empty  = (count_q == '0);
  assign full   = (count_q == CNT_W'(CAPACITY));

  // Append and replace write their word in the cycle they are accepted.
  assign direct_wr = accept &&
      (((mode == MODE_INSERT) && (pos_c == cnt_c) && !full) ||
       ((mode == MODE_REPLACE) && (pos_c < cnt_c)));

  // A returning word is the one taken out when it is the first match.
  assign hit = rv_q && !found_q && (force_q || (ram_rdata_i == val_q));

  // RAM port control.
  always_comb begin
    ram_re_o    = issue_q && ((state_q == S_SCAN) || (state_q == S_SHIFT));
    ram_raddr_o = rd_addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_a;
    ram_wdata_o = DATA_WIDTH'(value_i);
    case (state_q)
      S_IDLE: begin
        ram_we_o = direct_wr;
      end
      S_SCAN: begin
        // Words past the removed one move down by one place.
        ram_we_o    = rv_q && found_q;
        ram_waddr_o = ra_q - ADDR_W'(1);
        ram_wdata_o = ram_rdata_i;
      end
      S_SHIFT: begin
        // Words from the insert point up move up by one place.
        ram_we_o    = rv_q;
        ram_waddr_o = ra_q + ADDR_W'(1);
        ram_wdata_o = ram_rdata_i;
      end
      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = val_q;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign res_o.valid         = (state_q == S_FIN);
  assign res_o.status        = status_q;
  assign res_o.removed_value = VAL_W'(removed_q);
  assign res_o.length        = LEN_W'(count_q);

  // Sequencer state and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      val_q     <= '0;
      pos_q     <= '0;
      rd_addr_q <= '0;
      issue_q   <= 1'b0;
      rv_q      <= 1'b0;
      ra_q      <= '0;
      found_q   <= 1'b0;
      force_q   <= 1'b0;
      removed_q <= '0;
      status_q  <= ST_DONE;
    end else begin
      rv_q <= ram_re_o;
      ra_q <= rd_addr_q;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            val_q     <= DATA_WIDTH'(value_i);
            pos_q     <= pos_a;
            status_q  <= ST_DONE;
            removed_q <= '0;
            found_q   <= 1'b0;
            force_q   <= 1'b1;
            issue_q   <= 1'b0;
            state_q   <= S_FIN;
            case (mode)
              MODE_INSERT: begin
                if (pos_c > cnt_c) begin
                  status_q <= ST_BAD;
                end else if (full) begin
                  status_q <= ST_FULL;
                end else if (pos_c == cnt_c) begin
                  count_q <= count_q + CNT_W'(1);
                end else begin
                  rd_addr_q <= last_a;
                  issue_q   <= 1'b1;
                  state_q   <= S_SHIFT;
                end
              end
              MODE_RM_AT: begin
                if (pos_c >= cnt_c) begin
                  status_q <= ST_BAD;
                end else begin
                  rd_addr_q <= pos_a;
                  issue_q   <= 1'b1;
                  state_q   <= S_SCAN;
                end
              end
              MODE_RM_FIRST: begin
                if (empty) begin
                  status_q <= ST_BAD;
                end else begin
                  rd_addr_q <= '0;
                  issue_q   <= 1'b1;
                  state_q   <= S_SCAN;
                end
              end
              MODE_RM_LAST: begin
                if (empty) begin
                  status_q <= ST_BAD;
                end else begin
                  rd_addr_q <= last_a;
                  issue_q   <= 1'b1;
                  state_q   <= S_SCAN;
                end
              end
              MODE_RM_VALUE: begin
                if (empty) begin
                  status_q <= ST_BAD;
                end else begin
                  rd_addr_q <= '0;
                  issue_q   <= 1'b1;
                  force_q   <= 1'b0;
                  state_q   <= S_SCAN;
                end
              end
              MODE_REPLACE: begin
                if (pos_c >= cnt_c) begin
                  status_q <= ST_BAD;
                end
              end
              default: begin
                status_q <= ST_BAD;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Reads run upward to the last entry.
          if (issue_q) begin
            rd_addr_q <= rd_addr_q + ADDR_W'(1);
            if (rd_addr_q == last_a) begin
              issue_q <= 1'b0;
            end
          end
          if (hit) begin
            found_q   <= 1'b1;
            removed_q <= ram_rdata_i;
          end
          if (rv_q && (ra_q == last_a)) begin
            state_q <= S_FIN;
            if (found_q || hit) begin
              count_q <= count_q - CNT_W'(1);
            end else begin
              status_q <= ST_MISSING;
            end
          end
        end
        S_SHIFT: begin
          // Reads run downward to the insert point.
          if (issue_q) begin
            rd_addr_q <= rd_addr_q - ADDR_W'(1);
            if (rd_addr_q == pos_q) begin
              issue_q <= 1'b0;
            end
          end
          if (rv_q && (ra_q == pos_q)) begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          count_q <= count_q + CNT_W'(1);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/indexed_sequence_store.sv @@
`default_nettype none

// Indexed sequence store: an ordered list of up to CAPACITY words kept in one
// synchronous RAM. Each item asks to insert, remove (at a position, first,
// last, or first equal to a value) or replace, and returns one result item
// with a status, the removed word and the new length; a failed request
// changes nothing. One item is worked at a time. Append, replace and every
// rejected request go from acceptance straight to the result. Insert at
// position p and removals starting at position k pass every word from that
// position to the end once through the RAM's single read port and single
// write port (remove by value scans from the head). A finished result waits
// in an output register while the next item is accepted.
module indexed_sequence_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [iss_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [iss_pkg::POS_W-1:0]     position_i,
  input  wire logic [iss_pkg::VAL_W-1:0]     value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [iss_pkg::STAT_W-1:0]         status_o,
  output logic [iss_pkg::VAL_W-1:0]          removed_value_o,
  output logic [iss_pkg::LEN_W-1:0]          length_o
);

  import iss_pkg::*;

  res_t                  res;
  logic                  res_ready;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  out_valid_q;
  status_e               status_q;
  logic [VAL_W-1:0]      removed_q;
  logic [LEN_W-1:0]      length_q;

  iss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  iss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: a result moves in when the slot is empty or draining.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      removed_q   <= '0;
      length_q    <= '0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
      if (res.valid) begin
        status_q  <= res.status;
        removed_q <= res.removed_value;
        length_q  <= res.length;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign length_o        = length_q;

endmodule

`default_nettype wire
